/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and rst to be visible where they are used.

// Condition c must hold in the same cycle as a.
`define ASSERT_IMPL(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition c must hold in the cycle after a.
`define ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* src/tct_pkg.sv */
package tct_pkg;

  localparam int MAX_FINGERS_DEF = 16;
  localparam int MAX_BUTTONS_DEF = 64;
  localparam int POS_W           = 32;
  localparam int BTN_OUT_W       = 7;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_FINISH = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_BUTTON = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [POS_W-1:0]  finger_id;
    pos_t              pos;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [BTN_OUT_W-1:0]   button;
    pos_t                   pos;
    pos_t                   motion;
  } res_t;

  // Contact table write command
  typedef struct packed {
    logic set;
    logic pos_we;
    logic clear;
  } tbl_cmd_t;

  // Button allocator request
  typedef struct packed {
    logic take;
    logic give;
  } alloc_req_t;

endpackage

/* src/tct_if.sv */
interface tct_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        finger_id;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, req_type, finger_id, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, req_type, finger_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface tct_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [6:0]         button;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] motion_x;
  logic signed [31:0] motion_y;
  logic signed [31:0] motion_z;

  modport source (output valid, status, button, out_x, out_y, out_z,
                  motion_x, motion_y, motion_z, input ready);
  modport sink   (input valid, status, button, out_x, out_y, out_z,
                  motion_x, motion_y, motion_z, output ready);
endinterface

/* src/tct_ram.sv */
module tct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tct_button_alloc.sv */
`include "assert_macros.svh"

module tct_button_alloc import tct_pkg::*; #(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int BTN_W       = $clog2(MAX_BUTTONS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  alloc_req_t       req,
  input  logic [BTN_W-1:0] give_button,
  output logic             avail,
  output logic [BTN_W-1:0] alloc_button
);

  localparam int AW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

  logic [BTN_W-1:0] hw, hw_next;
  logic [BTN_W-1:0] count, count_next;
  logic [BTN_W-1:0] top, top_next;
  logic             use_ram;
  logic [BTN_W-1:0] rdata;
  logic [BTN_W-1:0] eff_top;
  logic [BTN_W-1:0] count_m1, count_m2;
  logic             pop, push, ram_we;

  // Top of stack lives in a register; the rest sits in RAM. After a pop the
  // new top comes out of the RAM read port in the next cycle.
  assign eff_top  = use_ram ? rdata : top;
  assign count_m1 = count - BTN_W'(1);
  assign count_m2 = count - BTN_W'(2);

  assign avail        = (count != '0) || (hw < BTN_W'(MAX_BUTTONS));
  assign alloc_button = (count != '0) ? eff_top : hw + BTN_W'(1);

  always_comb begin
    pop        = req.take && (count != '0);
    push       = 1'b0;
    hw_next    = hw;
    count_next = count;
    top_next   = eff_top;
    if (req.take) begin
      if (count != '0) begin
        count_next = count_m1;
      end else begin
        hw_next = hw + BTN_W'(1);
      end
    end else if (req.give) begin
      if (hw == give_button) begin
        hw_next = hw - BTN_W'(1);
      end else if (count < BTN_W'(MAX_BUTTONS)) begin
        push       = 1'b1;
        count_next = count + BTN_W'(1);
        top_next   = give_button;
      end
    end
  end

  // Push spills the old top into RAM.
  assign ram_we = push && (count != '0);

  tct_ram #(
    .WIDTH (BTN_W),
    .DEPTH (MAX_BUTTONS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_m1[AW-1:0]),
    .wdata (eff_top),
    .raddr (count_m2[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hw      <= '0;
      count   <= '0;
      use_ram <= 1'b0;
    end else begin
      hw      <= hw_next;
      count   <= count_next;
      use_ram <= pop;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  `ASSERT_NEXT(pop_lowers_count, req.take && count != '0, count == $past(count) - 1, "pop did not lower count")
  `ASSERT_NEXT(give_top_lowers_hw, req.give && hw == give_button, hw == $past(hw) - 1, "freeing top did not lower high-water mark")
  `ASSERT_IMPL(count_in_range, 1'b1, count <= BTN_W'(MAX_BUTTONS) && hw <= BTN_W'(MAX_BUTTONS), "stack count or high-water mark out of range")

endmodule

/* src/tct_contact_table.sv */
module tct_contact_table import tct_pkg::*; #(
  parameter int MAX_FINGERS = MAX_FINGERS_DEF,
  parameter int BTN_W       = 7,
  parameter int FW          = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      finger,
  input  tbl_cmd_t         cmd,
  input  logic [FW-1:0]    wr_idx,
  input  logic [BTN_W-1:0] wr_button,
  input  pos_t             wr_pos,
  output logic             hit,
  output logic [FW-1:0]    hit_idx,
  output logic             free_found,
  output logic [FW-1:0]    free_idx,
  output logic [BTN_W-1:0] rd_button,
  output pos_t             rd_pos
);

  logic [MAX_FINGERS-1:0] valid;
  logic [31:0]            ent_finger [MAX_FINGERS];
  logic [BTN_W-1:0]       ent_button [MAX_FINGERS];
  pos_t                   ent_pos    [MAX_FINGERS];
  logic [MAX_FINGERS-1:0] match;

  always_comb begin
    for (int i = 0; i < MAX_FINGERS; i++) begin
      match[i] = valid[i] && (ent_finger[i] == finger);
    end
  end

  // Lowest index wins for both searches.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = MAX_FINGERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = FW'(i);
      end
      if (!valid[i]) begin
        free_idx = FW'(i);
      end
    end
  end

  assign hit        = |match;
  assign free_found = ~&valid;
  assign rd_button  = ent_button[hit_idx];
  assign rd_pos     = ent_pos[hit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.set) begin
      valid[wr_idx] <= 1'b1;
    end else if (cmd.clear) begin
      valid[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      ent_finger[wr_idx] <= finger;
      ent_button[wr_idx] <= wr_button;
    end
    if (cmd.set || cmd.pos_we) begin
      ent_pos[wr_idx] <= wr_pos;
    end
  end

endmodule

/* src/touch_contact_tracker.sv */
// Touch contact tracker: takes begin, update and finish events for a finger
// id with an x/y/z position and returns one result beat per event, carrying
// a status, the finger's button number, the stored position and the motion
// (old minus new) since the previous event. One event per clock is sustained
// while rsp.ready takes each beat; an event held in the input register moves
// its result into the output register once that register is empty or being
// taken. The rate is set by the loop that matches the finger id against all
// contact entries in parallel and updates the table and the button free stack
// in the same cycle; the free stack's top is kept in a register so its RAM's
// registered read never stalls a begin. No clearing pass follows reset.
`include "assert_macros.svh"

module touch_contact_tracker import tct_pkg::*; #(
  parameter int MAX_FINGERS = MAX_FINGERS_DEF,
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
  input logic        clk,
  input logic        rst,
  tct_req_if.sink    req,
  tct_rsp_if.source  rsp
);

  localparam int FW    = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
  localparam int BTN_W = $clog2(MAX_BUTTONS + 1);

  logic             in_vld, out_vld, adv, fire;
  req_t             in_q;
  res_t             out_q, res;
  tbl_cmd_t         tcmd;
  alloc_req_t       areq;
  logic [FW-1:0]    wr_idx, hit_idx, free_idx;
  logic             hit, free_found, avail;
  logic [BTN_W-1:0] rd_button, alloc_btn;
  pos_t             rd_pos;

  assign adv       = !out_vld || rsp.ready;
  assign req.ready = !in_vld || adv;
  assign fire      = in_vld && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (req.ready) begin
        in_vld <= req.valid;
      end
      if (adv) begin
        out_vld <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q.req_type  <= req.req_type;
      in_q.finger_id <= req.finger_id;
      in_q.pos.x     <= req.pos_x;
      in_q.pos.y     <= req.pos_y;
      in_q.pos.z     <= req.pos_z;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  tct_contact_table #(
    .MAX_FINGERS (MAX_FINGERS),
    .BTN_W       (BTN_W),
    .FW          (FW)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .finger     (in_q.finger_id),
    .cmd        (tcmd),
    .wr_idx     (wr_idx),
    .wr_button  (alloc_btn),
    .wr_pos     (in_q.pos),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .free_found (free_found),
    .free_idx   (free_idx),
    .rd_button  (rd_button),
    .rd_pos     (rd_pos)
  );

  tct_button_alloc #(
    .MAX_BUTTONS (MAX_BUTTONS),
    .BTN_W       (BTN_W)
  ) u_alloc (
    .clk          (clk),
    .rst          (rst),
    .req          (areq),
    .give_button  (rd_button),
    .avail        (avail),
    .alloc_button (alloc_btn)
  );

  // Error and reserved events leave all payload at zero and state untouched.
  always_comb begin
    res        = '0;
    res.status = ST_OK;
    tcmd       = '0;
    areq       = '0;
    wr_idx     = hit_idx;
    case (req_kind_t'(in_q.req_type))
      KIND_BEGIN: begin
        if (!(hit || free_found)) begin
          res.status = ST_FULL;
        end else if (!avail) begin
          res.status = ST_NO_BUTTON;
        end else begin
          tcmd.set   = fire;
          areq.take  = fire;
          wr_idx     = hit ? hit_idx : free_idx;
          res.button = BTN_OUT_W'(alloc_btn);
          res.pos    = in_q.pos;
        end
      end
      KIND_UPDATE, KIND_FINISH: begin
        if (!hit) begin
          res.status = ST_UNKNOWN;
        end else begin
          tcmd.pos_we  = fire;
          res.button   = BTN_OUT_W'(rd_button);
          res.pos      = in_q.pos;
          res.motion.x = rd_pos.x - in_q.pos.x;
          res.motion.y = rd_pos.y - in_q.pos.y;
          res.motion.z = rd_pos.z - in_q.pos.z;
          if (in_q.req_type == KIND_FINISH) begin
            tcmd.clear = fire;
            areq.give  = fire;
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  assign rsp.valid    = out_vld;
  assign rsp.status   = out_q.status;
  assign rsp.button   = out_q.button;
  assign rsp.out_x    = out_q.pos.x;
  assign rsp.out_y    = out_q.pos.y;
  assign rsp.out_z    = out_q.pos.z;
  assign rsp.motion_x = out_q.motion.x;
  assign rsp.motion_y = out_q.motion.y;
  assign rsp.motion_z = out_q.motion.z;

  `ASSERT_IMPL(err_beat_zero, out_vld && out_q.status != ST_OK, out_q.button == '0 && out_q.motion == '0 && out_q.pos == '0, "error beat carries payload")
  `ASSERT_IMPL(take_nonzero, areq.take, alloc_btn != '0, "allocated button zero")
  `ASSERT_IMPL(take_give_excl, fire, !(areq.take && areq.give) && !(tcmd.set && tcmd.clear), "conflicting state updates")

endmodule
